// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms. The enclosing module provides clk and rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ALTK_CHECK(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define ALTK_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/altk_pkg.sv =====
// ----------------------------------------------------------------------------
// altk_pkg
// Types, character codes and the byte classifier of the assembly line tokenizer.
// ----------------------------------------------------------------------------
package altk_pkg;

  localparam int MAX_TOKENS = 16;
  localparam int CNT_W      = $clog2(MAX_TOKENS + 1);

  localparam logic [7:0] POS_MAX  = 8'hFF;
  localparam logic [7:0] MIN_LINE = 8'd2;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_AMP   = 8'h26;
  localparam logic [7:0] CH_PIPE  = 8'h7C;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_LPAR  = 8'h28;
  localparam logic [7:0] CH_RPAR  = 8'h29;
  localparam logic [7:0] CH_LBRK  = 8'h5B;
  localparam logic [7:0] CH_RBRK  = 8'h5D;
  localparam logic [7:0] CH_LBRC  = 8'h7B;
  localparam logic [7:0] CH_RBRC  = 8'h7D;

  // Class of the open token.
  typedef enum logic [1:0] {
    CLS_WORD  = 2'd0,
    CLS_SYM   = 2'd1,
    CLS_PUNCT = 2'd2
  } cls_t;

  // Kind of an incoming byte within a line.
  typedef enum logic [1:0] {
    KIND_WORD  = 2'd0,
    KIND_SYM   = 2'd1,
    KIND_PUNCT = 2'd2,
    KIND_SPACE = 2'd3
  } kind_t;

  typedef struct packed {
    logic  eol;
    kind_t kind;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } stage_t;

  typedef struct packed {
    logic       token_valid;
    logic [7:0] token_offset;
    logic [7:0] token_length;
    logic [3:0] token_index;
    logic       line_done;
    logic       table_overflow;
    logic       line_too_long;
  } result_t;

  typedef struct packed {
    logic    push;
    result_t res;
  } push_t;

  function automatic kind_t classify(input logic [7:0] c);
    kind_t k;
    unique case (c) inside
      CH_SPACE, CH_TAB:
        k = KIND_SPACE;
      CH_COMMA, CH_SEMI, CH_LPAR, CH_RPAR, CH_LBRK, CH_RBRK, CH_LBRC, CH_RBRC:
        k = KIND_PUNCT;
      CH_EQ, CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH, CH_AMP, CH_PIPE, CH_CARET:
        k = KIND_SYM;
      default:
        k = KIND_WORD;
    endcase
    return k;
  endfunction

endpackage

// ===== sv/altk_in_if.sv =====
// ----------------------------------------------------------------------------
// altk_in_if
// Source byte channel: valid/ready handshake with action and byte payload.
// ----------------------------------------------------------------------------
interface altk_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] char_in;

  modport source(output valid, action, char_in, input ready);
  modport sink(input valid, action, char_in, output ready);
endinterface

// ===== sv/altk_tok_if.sv =====
// ----------------------------------------------------------------------------
// altk_tok_if
// Token result channel: valid/ready handshake with one token or line end.
// ----------------------------------------------------------------------------
interface altk_tok_if;
  logic       valid;
  logic       ready;
  logic       token_valid;
  logic [7:0] token_offset;
  logic [7:0] token_length;
  logic [3:0] token_index;
  logic       line_done;
  logic       table_overflow;
  logic       line_too_long;

  modport source(output valid, token_valid, token_offset, token_length, token_index,
                 line_done, table_overflow, line_too_long, input ready);
  modport sink(input valid, token_valid, token_offset, token_length, token_index,
               line_done, table_overflow, line_too_long, output ready);
endinterface

// ===== sv/altk_in_stage.sv =====
// ----------------------------------------------------------------------------
// altk_in_stage
// Input register: captures one source beat and its decoded byte kind.
// ----------------------------------------------------------------------------
module altk_in_stage (
  input  logic            clk,
  input  logic            rst,
  altk_in_if.sink         feed,
  input  logic            take,
  output altk_pkg::stage_t stage
);

  logic            valid;
  altk_pkg::item_t item;
  logic            accept;

  // Refill in the same cycle the held beat moves on.
  assign feed.ready = !valid || take;
  assign accept     = feed.valid && feed.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (take) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item.eol  <= feed.action || (feed.char_in == altk_pkg::CH_NL);
      item.kind <= altk_pkg::classify(feed.char_in);
    end
  end

  assign stage.valid = valid;
  assign stage.item  = item;

endmodule

// ===== sv/altk_lexer.sv =====
// ----------------------------------------------------------------------------
// altk_lexer
// Line state and token boundary logic; one byte per cycle while the result buffer is not full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module altk_lexer (
  input  logic             clk,
  input  logic             rst,
  input  altk_pkg::stage_t stage,
  input  logic             full,
  output logic             take,
  output altk_pkg::push_t  wr
);

  logic [7:0]                 line_position, line_position_next;
  logic [7:0]                 open_token_start, open_token_start_next;
  logic                       token_open, token_open_next;
  altk_pkg::cls_t             open_token_class, open_token_class_next;
  logic [altk_pkg::CNT_W-1:0] tokens_in_line, tokens_in_line_next;
  logic                       overflow_seen, overflow_seen_next;
  logic                       too_long_seen, too_long_seen_next;

  logic       at_max;
  logic       close;
  logic       open_new;
  altk_pkg::cls_t new_cls;
  logic       room;
  logic       keep;
  logic       drop;
  logic [7:0] length;

  assign take   = stage.valid && !full;
  assign at_max = (line_position == altk_pkg::POS_MAX);
  assign room   = (tokens_in_line < altk_pkg::CNT_W'(altk_pkg::MAX_TOKENS));
  assign length = line_position - open_token_start;

  // Token boundary decision.
  always_comb begin
    close    = 1'b0;
    open_new = 1'b0;
    new_cls  = altk_pkg::CLS_WORD;
    if (stage.item.eol) begin
      close = token_open && (line_position >= altk_pkg::MIN_LINE);
    end else begin
      unique case (stage.item.kind)
        altk_pkg::KIND_SPACE: begin
          close = token_open;
        end
        altk_pkg::KIND_PUNCT: begin
          close    = token_open;
          open_new = 1'b1;
          new_cls  = altk_pkg::CLS_PUNCT;
        end
        altk_pkg::KIND_SYM: begin
          // extend a running symbol token
          if (!(token_open && open_token_class == altk_pkg::CLS_SYM)) begin
            close    = token_open;
            open_new = 1'b1;
            new_cls  = altk_pkg::CLS_SYM;
          end
        end
        altk_pkg::KIND_WORD: begin
          if (!token_open) begin
            open_new = 1'b1;
          end else if (open_token_class != altk_pkg::CLS_WORD) begin
            close    = 1'b1;
            open_new = 1'b1;
          end
        end
        default: begin
          close = 1'b0;
        end
      endcase
    end
  end

  assign keep = close && room;
  assign drop = close && !room;

  // Result beat.
  always_comb begin
    wr.push               = take && (stage.item.eol || keep);
    wr.res.token_valid    = keep;
    wr.res.token_offset   = keep ? open_token_start : 8'd0;
    wr.res.token_length   = keep ? length : 8'd0;
    wr.res.token_index    = keep ? 4'(tokens_in_line) : 4'd0;
    wr.res.line_done      = stage.item.eol;
    wr.res.table_overflow = overflow_seen || drop;
    wr.res.line_too_long  = too_long_seen || (!stage.item.eol && at_max);
  end

  // Next line state.
  always_comb begin
    if (stage.item.eol) begin
      line_position_next    = 8'd0;
      open_token_start_next = 8'd0;
      token_open_next       = 1'b0;
      open_token_class_next = altk_pkg::CLS_WORD;
      tokens_in_line_next   = '0;
      overflow_seen_next    = 1'b0;
      too_long_seen_next    = 1'b0;
    end else begin
      line_position_next    = at_max ? altk_pkg::POS_MAX : line_position + 8'd1;
      open_token_start_next = open_new ? line_position : open_token_start;
      open_token_class_next = open_new ? new_cls : open_token_class;
      token_open_next       = open_new || (token_open && !close &&
                                           stage.item.kind != altk_pkg::KIND_SPACE);
      tokens_in_line_next   = tokens_in_line + altk_pkg::CNT_W'(keep);
      overflow_seen_next    = overflow_seen || drop;
      too_long_seen_next    = too_long_seen || at_max;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_position    <= 8'd0;
      open_token_start <= 8'd0;
      token_open       <= 1'b0;
      open_token_class <= altk_pkg::CLS_WORD;
      tokens_in_line   <= '0;
      overflow_seen    <= 1'b0;
      too_long_seen    <= 1'b0;
    end else if (take) begin
      line_position    <= line_position_next;
      open_token_start <= open_token_start_next;
      token_open       <= token_open_next;
      open_token_class <= open_token_class_next;
      tokens_in_line   <= tokens_in_line_next;
      overflow_seen    <= overflow_seen_next;
      too_long_seen    <= too_long_seen_next;
    end
  end

  `ALTK_CHECK_NEXT(a_line_clear, take && stage.item.eol, (line_position == 8'd0) && !token_open && (tokens_in_line == '0), "line state not cleared after line end")
  `ALTK_CHECK(a_mid_push_token, wr.push && !stage.item.eol, wr.res.token_valid, "mid-line result without a token")

endmodule

// ===== sv/altk_out_buf.sv =====
// ----------------------------------------------------------------------------
// altk_out_buf
// Two-entry result buffer that decouples the lexer from the result sink.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module altk_out_buf (
  input  logic            clk,
  input  logic            rst,
  input  altk_pkg::push_t wr,
  output logic            full,
  altk_tok_if.source      tokens
);

  altk_pkg::result_t mem [2];
  logic              wr_ptr;
  logic              rd_ptr;
  logic [1:0]        count;
  logic              pop;
  altk_pkg::result_t head;

  assign full = (count == 2'd2);
  assign pop  = tokens.valid && tokens.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (wr.push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      if (wr.push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !wr.push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wr_ptr] <= wr.res;
    end
  end

  assign head                  = mem[rd_ptr];
  assign tokens.valid          = (count != 2'd0);
  assign tokens.token_valid    = head.token_valid;
  assign tokens.token_offset   = head.token_offset;
  assign tokens.token_length   = head.token_length;
  assign tokens.token_index    = head.token_index;
  assign tokens.line_done      = head.line_done;
  assign tokens.table_overflow = head.table_overflow;
  assign tokens.line_too_long  = head.line_too_long;

  `ALTK_CHECK(a_no_push_full, full, !wr.push, "result beat pushed into full buffer")
  `ALTK_CHECK_NEXT(a_pop_drains, pop && !wr.push, count == $past(count) - 2'd1, "buffer count did not drop on pop")

endmodule

// ===== sv/assembly_line_tokenizer_top.sv =====
// ----------------------------------------------------------------------------
// assembly_line_tokenizer_top
// Splits assembly source bytes into lines and tokens, one byte per beat.
// ----------------------------------------------------------------------------
// Takes one source byte (or an end-of-data beat) every cycle while not stalled
// and returns at most one result per input beat: a finished token as offset
// and length in its line, or a line-end beat. An accepted beat is held in the
// input register while the lexer, whose line state update sets the rate of one
// byte per clock, writes its result into a two-entry result buffer, from which
// it is presented at the output. The buffer lets input continue while a result
// waits to be taken; input stalls only when that buffer is full and the input
// register already holds a beat.
module assembly_line_tokenizer_top (
  input  logic       clk,
  input  logic       rst,
  altk_in_if.sink    feed,
  altk_tok_if.source tokens
);

  altk_pkg::stage_t stage;
  altk_pkg::push_t  wr;
  logic             take;
  logic             full;

  altk_in_stage u_in_stage (
    .clk   (clk),
    .rst   (rst),
    .feed  (feed),
    .take  (take),
    .stage (stage)
  );

  altk_lexer u_lexer (
    .clk   (clk),
    .rst   (rst),
    .stage (stage),
    .full  (full),
    .take  (take),
    .wr    (wr)
  );

  altk_out_buf u_out_buf (
    .clk    (clk),
    .rst    (rst),
    .wr     (wr),
    .full   (full),
    .tokens (tokens)
  );

endmodule
